// ===== hw/rtl/scb_pkg.sv =====
// Types and character constants shared by the comment blanker modules.
package scb_pkg;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [1:0] MODE_C      = 2'd0;
  localparam logic [1:0] MODE_PYTHON = 2'd1;
  localparam logic [1:0] MODE_ASM    = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [1:0] language_mode;
  } cfg_item_t;

  typedef struct packed {
    logic inside_string;
    logic quote_is_single;
    logic escape_pending;
    logic inside_block_comment;
    logic inside_line_comment;
    logic char_held;
  } scb_state_t;

  // Results produced by one item, in order; cnt is 0, 1 or 2.
  typedef struct packed {
    logic [1:0]           cnt;
    out_item_t [1:0]      res;
  } scb_push_t;

endpackage

// ===== hw/rtl/scb_chan_if.sv =====
// Valid/ready channel carrying one item of payload type T.
interface scb_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/scb_step.sv =====
// Scanner state and the per-item blanking logic.
module scb_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        mode_i,
  input  logic              fire_i,
  input  scb_pkg::in_item_t item_i,
  output scb_pkg::scb_push_t push_o
);
  import scb_pkg::*;

  typedef struct packed {
    logic       emit;
    logic [7:0] out;
    scb_state_t st;
  } fresh_t;

  scb_state_t state_q, state_d;
  logic [1:0] n;
  out_item_t [1:0] res;

  // Handle a byte that does not complete a held opener or closer.
  function automatic fresh_t handle_fresh(input logic [7:0] c, input logic [1:0] mode,
                                          input scb_state_t s);
    fresh_t r;
    r.st   = s;
    r.emit = 1'b1;
    r.out  = c;
    if (s.escape_pending) begin
      r.st.escape_pending = 1'b0;
    end else if (s.inside_string) begin
      if (c == CH_BSLASH) begin
        r.st.escape_pending = 1'b1;
      end else if (c == (s.quote_is_single ? CH_SQUOTE : CH_DQUOTE)) begin
        r.st.inside_string = 1'b0;
      end
    end else if (s.inside_line_comment) begin
      if (c == CH_NL) begin
        r.st.inside_line_comment = 1'b0;
      end else begin
        r.out = CH_SPACE;
      end
    end else if (s.inside_block_comment) begin
      if (c == CH_STAR) begin
        r.st.char_held = 1'b1;
        r.emit = 1'b0;
      end else begin
        r.out = (c == CH_NL) ? CH_NL : CH_SPACE;
      end
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      r.st.inside_string   = 1'b1;
      r.st.quote_is_single = (c == CH_SQUOTE);
    end else begin
      case (mode)
        MODE_PYTHON: begin
          if (c == CH_HASH) begin
            r.st.inside_line_comment = 1'b1;
            r.out = CH_SPACE;
          end
        end
        MODE_ASM: begin
          if (c == CH_SEMI || c == CH_HASH) begin
            r.st.inside_line_comment = 1'b1;
            r.out = CH_SPACE;
          end
        end
        default: begin
          if (c == CH_SLASH) begin
            r.st.char_held = 1'b1;
            r.emit = 1'b0;
          end
        end
      endcase
    end
    return r;
  endfunction

  always_comb begin
    fresh_t     f;
    logic       do_fresh;
    logic [7:0] c;
    c        = item_i.text_byte;
    state_d  = state_q;
    n        = 2'd0;
    res      = '0;
    do_fresh = 1'b1;
    f        = '0;

    // Resolve a held slash or star against this byte.
    if (state_q.char_held) begin
      state_d.char_held = 1'b0;
      if (state_q.inside_block_comment) begin
        res[0].out_byte = CH_SPACE;
        n = 2'd1;
        if (c == CH_SLASH) begin
          res[1].out_byte = CH_SPACE;
          n = 2'd2;
          state_d.inside_block_comment = 1'b0;
          do_fresh = 1'b0;
        end
      end else if (c == CH_STAR || c == CH_SLASH) begin
        res[0].out_byte = CH_SPACE;
        res[1].out_byte = CH_SPACE;
        n = 2'd2;
        state_d.inside_block_comment = (c == CH_STAR);
        state_d.inside_line_comment  = (c == CH_SLASH);
        do_fresh = 1'b0;
      end else begin
        res[0].out_byte = CH_SLASH;
        n = 2'd1;
      end
    end

    if (do_fresh) begin
      f = handle_fresh(c, mode_i, state_d);
      state_d = f.st;
      if (f.emit) begin
        res[n[0]].out_byte = f.out;
        n = n + 2'd1;
      end
    end

    // Flush a held byte on the final byte of the text.
    if (item_i.end_of_text && state_d.char_held) begin
      state_d.char_held = 1'b0;
      res[n[0]].out_byte = state_d.inside_block_comment ? CH_SPACE : CH_SLASH;
      n = n + 2'd1;
    end

    if (n == 2'd1) res[0].last_of_run = 1'b1;
    if (n == 2'd2) res[1].last_of_run = 1'b1;

    push_o.cnt = fire_i ? n : 2'd0;
    push_o.res = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.char_held |-> !state_q.inside_string && !state_q.inside_line_comment)
    else $error("held byte inside a string or line comment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.escape_pending |-> state_q.inside_string)
    else $error("escape pending outside a string");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.end_of_text) |=> !state_q.char_held)
    else $error("held byte survived the end of text");

endmodule

// ===== hw/rtl/scb_out_buf.sv =====
// Three-entry result queue that takes up to two results a cycle.
module scb_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scb_pkg::scb_push_t  push_i,
  output logic                space_o,
  scb_chan_if.source          out_chan
);
  import scb_pkg::*;

  localparam int Depth = 3;
  localparam int CntW  = $clog2(Depth + 1);

  out_item_t [Depth-1:0] ent_q, ent_d;
  logic [CntW-1:0]       cnt_q, cnt_d, cnt_after, idx;
  logic                  pop;

  assign pop            = out_chan.valid && out_chan.ready;
  assign out_chan.valid = (cnt_q != '0);
  assign out_chan.data  = ent_q[0];
  // Room for a full pair whatever the sink does this cycle.
  assign space_o        = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    cnt_after = cnt_q - CntW'(pop);
    ent_d     = ent_q;
    idx       = '0;
    if (pop) begin
      for (int k = 0; k < Depth - 1; k++) begin
        ent_d[k] = ent_q[k+1];
      end
    end
    for (int k = 0; k < Depth; k++) begin
      idx = CntW'(k) - cnt_after;
      if (CntW'(k) >= cnt_after && idx < CntW'(push_i.cnt)) begin
        ent_d[k] = push_i.res[idx[0]];
      end
    end
    cnt_d = cnt_after + CntW'(push_i.cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> (cnt_q <= CntW'(Depth - 2)))
    else $error("results pushed without room for a pair");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt == 2'd2) |-> push_i.res[1].last_of_run && !push_i.res[0].last_of_run)
    else $error("last flag misplaced in a pair");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cnt_q == $past(cnt_q) + CntW'($past(push_i.cnt)) - CntW'($past(pop)))
    else $error("queue count out of step");

endmodule

// ===== hw/rtl/source_comment_blanker.sv =====
// An item waits in input register in_q until the result queue has room for a pair, then its
// results go into the queue. Throughput: one byte per cycle while it has room; items that give
// two results stall the input, as the three-entry queue drains at most one result per cycle.
// Reset (rst_ni low, asynchronous): scanner flags, held byte and queues cleared, mode set to C.
// Configuration writes are always taken and apply to the next item scanned.
module source_comment_blanker (
  input  logic       clk_i,
  input  logic       rst_ni,
  scb_chan_if.sink   cfg_chan,
  scb_chan_if.sink   in_chan,
  scb_chan_if.source out_chan
);
  import scb_pkg::*;

  logic [1:0] mode_q;
  logic       in_vld_q;
  in_item_t   in_q;
  logic       space;
  logic       step_fire;
  scb_push_t  push;

  assign cfg_chan.ready = 1'b1;

  assign step_fire     = in_vld_q && space;
  assign in_chan.ready = !in_vld_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_C;
    end else if (cfg_chan.valid) begin
      mode_q <= cfg_chan.data.language_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_vld_q <= 1'b1;
    end else if (step_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.valid && in_chan.ready) begin
      in_q <= in_chan.data;
    end
  end

  scb_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .fire_i (step_fire),
    .item_i (in_q),
    .push_o (push)
  );

  scb_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .space_o  (space),
    .out_chan (out_chan)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && in_q.end_of_text) |-> (push.cnt != 2'd0))
    else $error("final byte of text gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !space) |=> in_vld_q && $stable(in_q))
    else $error("stalled item lost from the input register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan.valid && in_chan.ready) |=> in_vld_q)
    else $error("accepted item not captured");

endmodule

// ===== verif/scb_checker.sv =====
// Checker for the comment blanker: predicts each item's output bytes and compares them.
module scb_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  scb_pkg::cfg_item_t cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  scb_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  scb_pkg::out_item_t out_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  import scb_pkg::*;

  logic [1:0] lang_mode;
  scb_state_t scan;
  logic [7:0] step_bytes[$];
  out_item_t  expected_bytes[$];

  task automatic emit_byte(input logic [7:0] b);
    step_bytes.push_back(b);
  endtask

  // Scan a byte that is not the partner of a held one.
  task automatic scan_fresh(input logic [7:0] c);
    if (scan.escape_pending) begin
      scan.escape_pending = 1'b0;
      emit_byte(c);
    end else if (scan.inside_string) begin
      if (c == CH_BSLASH) begin
        scan.escape_pending = 1'b1;
      end else if (c == (scan.quote_is_single ? CH_SQUOTE : CH_DQUOTE)) begin
        scan.inside_string = 1'b0;
      end
      emit_byte(c);
    end else if (scan.inside_line_comment) begin
      if (c == CH_NL) begin
        scan.inside_line_comment = 1'b0;
      end
      emit_byte(c == CH_NL ? CH_NL : CH_SPACE);
    end else if (scan.inside_block_comment) begin
      if (c == CH_STAR) begin
        scan.char_held = 1'b1;
      end else begin
        emit_byte(c == CH_NL ? CH_NL : CH_SPACE);
      end
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      scan.inside_string   = 1'b1;
      scan.quote_is_single = (c == CH_SQUOTE);
      emit_byte(c);
    end else if ((lang_mode == MODE_PYTHON && c == CH_HASH) ||
                 (lang_mode == MODE_ASM && (c == CH_SEMI || c == CH_HASH))) begin
      scan.inside_line_comment = 1'b1;
      emit_byte(CH_SPACE);
    end else if (lang_mode != MODE_PYTHON && lang_mode != MODE_ASM && c == CH_SLASH) begin
      scan.char_held = 1'b1;
    end else begin
      emit_byte(c);
    end
  endtask

  task automatic blank_step(input in_item_t it);
    logic [7:0] c;
    out_item_t  r;
    c = it.text_byte;
    step_bytes.delete();
    if (scan.char_held) begin
      scan.char_held = 1'b0;
      if (scan.inside_block_comment) begin
        if (c == CH_SLASH) begin
          emit_byte(CH_SPACE);
          emit_byte(CH_SPACE);
          scan.inside_block_comment = 1'b0;
        end else begin
          emit_byte(CH_SPACE);
          scan_fresh(c);
        end
      end else if (c == CH_STAR) begin
        emit_byte(CH_SPACE);
        emit_byte(CH_SPACE);
        scan.inside_block_comment = 1'b1;
      end else if (c == CH_SLASH) begin
        emit_byte(CH_SPACE);
        emit_byte(CH_SPACE);
        scan.inside_line_comment = 1'b1;
      end else begin
        emit_byte(CH_SLASH);
        scan_fresh(c);
      end
    end else begin
      scan_fresh(c);
    end
    // End of text flushes the held byte only
    if (it.end_of_text && scan.char_held) begin
      scan.char_held = 1'b0;
      emit_byte(scan.inside_block_comment ? CH_SPACE : CH_SLASH);
    end
    foreach (step_bytes[i]) begin
      r.out_byte    = step_bytes[i];
      r.last_of_run = (i == step_bytes.size() - 1);
      expected_bytes.push_back(r);
    end
  endtask

  always @(posedge clk_i) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      lang_mode = MODE_C;
      scan      = '0;
      expected_bytes.delete();
    end else begin
      // Compare before taking new items: a result never belongs to an item of the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h/%b", $time,
                   out_data_i.out_byte, out_data_i.last_of_run);
          errors_o++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data_i.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch, expected %h, actual %h", $time,
                     want.out_byte, out_data_i.out_byte);
            errors_o++;
          end
          if (out_data_i.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run mismatch, expected %b, actual %b", $time,
                     want.last_of_run, out_data_i.last_of_run);
            errors_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        lang_mode = cfg_data_i.language_mode;
      end
      if (in_valid_i && in_ready_i) begin
        blank_step(in_data_i);
      end
    end
    pending_o = expected_bytes.size();
  end

endmodule

// ===== verif/tb_source_comment_blanker.sv =====
// Testbench top for the comment blanker: clock, reset, stimulus, stalls and verdict.
module tb_source_comment_blanker;
  import scb_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         HOLD_OFF    = 200;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int errors;
  int pending;
  int send_idle;
  int recv_stall;
  int bytes_sent;
  bit hold_off_req;

  always #5 clk_i = ~clk_i;

  scb_chan_if #(.T(cfg_item_t)) cfg_chan ();
  scb_chan_if #(.T(in_item_t))  in_chan ();
  scb_chan_if #(.T(out_item_t)) out_chan ();

  source_comment_blanker dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  scb_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_chan.valid),
    .cfg_ready_i (cfg_chan.ready),
    .cfg_data_i  (cfg_chan.data),
    .in_valid_i  (in_chan.valid),
    .in_ready_i  (in_chan.ready),
    .in_data_i   (in_chan.data),
    .out_valid_i (out_chan.valid),
    .out_ready_i (out_chan.ready),
    .out_data_i  (out_chan.data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= recv_stall);
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_source_comment_blanker: errors");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    in_item_t it;
    while ($urandom_range(0, 99) < send_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    it.text_byte = b;
    it.end_of_text = eot;
    in_chan.valid <= 1'b1;
    in_chan.data  <= it;
    do @(posedge clk_i); while (!in_chan.ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit eot_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot_last && i == s.len() - 1);
    end
  endtask

  // Drop valid and wait for every expected byte
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_item_t w;
    w.language_mode = m;
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= w;
    do @(posedge clk_i); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  // Bias towards the characters that drive the scanner
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0, 1:    return CH_SLASH;
      2, 3:    return CH_STAR;
      4:       return CH_DQUOTE;
      5:       return CH_SQUOTE;
      6:       return CH_BSLASH;
      7:       return CH_NL;
      8:       return CH_HASH;
      9:       return CH_SEMI;
      14, 15:  return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  task automatic send_body(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(pick_byte(), $urandom_range(0, 49) == 0);
    end
  endtask

  // One token: a comment or string with random content, or a little noise
  task automatic send_token();
    int         kind;
    logic [7:0] q;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      send_byte(CH_SLASH, 1'b0);
      send_byte(CH_STAR, 1'b0);
      send_body($urandom_range(0, 6));
      send_byte(CH_STAR, 1'b0);
      send_byte(CH_SLASH, $urandom_range(0, 9) == 0);
    end else if (kind <= 4) begin
      case ($urandom_range(0, 2))
        0: begin
          send_byte(CH_SLASH, 1'b0);
          send_byte(CH_SLASH, 1'b0);
        end
        1: send_byte(CH_HASH, 1'b0);
        default: send_byte(CH_SEMI, 1'b0);
      endcase
      send_body($urandom_range(0, 5));
      send_byte(CH_NL, $urandom_range(0, 9) == 0);
    end else if (kind <= 6) begin
      q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
      send_byte(q, 1'b0);
      for (int i = $urandom_range(0, 5); i > 0; i--) begin
        if ($urandom_range(0, 3) == 0) begin
          send_byte(CH_BSLASH, 1'b0);
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_byte(pick_byte(), 1'b0);
        end
      end
      send_byte(q, $urandom_range(0, 9) == 0);
    end else begin
      send_body($urandom_range(1, 3));
    end
  endtask

  initial begin : stimulus
    int target;
    in_chan.valid  <= 1'b0;
    in_chan.data   <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.data  <= '0;
    send_idle    = 0;
    recv_stall   = 0;
    bytes_sent   = 0;
    hold_off_req = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // C mode from reset: unpaired slash, block comment with quote and stray star,
    // line comment, escaped quote in a string, top byte, flush of a held slash
    send_text("/a/*'\n*x*/b//c\n\"\\\"\"", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_SLASH, 1'b1);
    settle();
    write_mode(MODE_PYTHON);
    send_text("#'\n'#'", 1'b1);
    settle();
    write_mode(MODE_ASM);
    send_text("a;\n#", 1'b1);
    settle();
    // Unused mode acts as C; a held star inside a block comment flushes as a space
    write_mode(MODE_UNUSED);
    send_text("/**", 1'b1);
    settle();

    // Hold the receiver off while items keep coming, so the input stalls
    write_mode(MODE_C);
    hold_off_req = 1'b1;
    target = bytes_sent + 40;
    while (bytes_sent < target) send_token();
    settle();

    for (int p = 0; p < 8; p++) begin
      write_mode(2'(p % 4));
      case ((p + p / 4) % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 55; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 55; end
        default: begin send_idle = 19; recv_stall = 19; end
      endcase
      target = bytes_sent + 200;
      while (bytes_sent < target) send_token();
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("tb_source_comment_blanker: clean");
    end else begin
      $display("tb_source_comment_blanker: errors");
    end
    $finish;
  end

endmodule

// ===== source_comment_blanker.f =====
hw/rtl/scb_pkg.sv
hw/rtl/scb_chan_if.sv
hw/rtl/scb_step.sv
hw/rtl/scb_out_buf.sv
hw/rtl/source_comment_blanker.sv
verif/scb_checker.sv
verif/tb_source_comment_blanker.sv
